[rtl/wrm_pkg.sv]
`default_nettype none

package wrm_pkg;

  localparam int RING_DEPTH = 64;

  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int LEVEL_W   = 32;
  localparam int DELTA_W   = LEVEL_W + 1;
  localparam int STEP_W    = 16;
  localparam int WIN_W     = 24;
  localparam int SUM_W     = 64;
  localparam int RATE_W    = 32;
  localparam int SAMPLES_W = 7;
  localparam int FRAC_W    = 16;
  localparam int ENTRY_W   = DELTA_W + STEP_W;

  // summed step time and delta over a full ring walk
  localparam int TDT_W     = PTR_W + STEP_W;
  localparam int TDELTA_W  = DELTA_W + CNT_W;
  localparam int CMP_W     = ((TDT_W > WIN_W) ? TDT_W : WIN_W) + 1;

  // divider: |delta| * 2^16 over summed step time
  localparam int NUM_W     = TDELTA_W + FRAC_W;
  localparam int DEN_W     = TDT_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam int MIN_DT    = 6;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [LEVEL_W-1:0] level;
    logic signed [LEVEL_W-1:0] prev_level;
    logic [STEP_W-1:0]         step_time;
    logic [WIN_W-1:0]          window_time;
  } in_item_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] peak_level;
    logic signed [LEVEL_W-1:0] min_level;
    logic signed [SUM_W-1:0]   level_sum;
    logic signed [RATE_W-1:0]  instant_rate;
    logic signed [RATE_W-1:0]  rolling_rate;
    logic [SAMPLES_W-1:0]      samples_held;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/wrm_in_if.sv]
`default_nettype none

interface wrm_in_if;
  import wrm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/wrm_out_if.sv]
`default_nettype none

interface wrm_out_if;
  import wrm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/windowed_rate_meter.sv]
// Channel | Dir | Fields
// in_ch   | in  | cmd, level, prev_level, step_time, window_time
// out_ch  | out | peak_level, min_level, level_sum, instant_rate, rolling_rate, samples_held
//
// One item at a time: in_ch is ready only while idle; the result holds until its transfer.
// Start and unused commands answer in the cycle after acceptance. A sample's rate is set
// by the bit-serial divider, which is skipped when the step time is at most MIN_DT. A query
// walks the ring one entry a cycle, then divides the same way.
// Reset clears control and level registers only; ring entries are read only after a
// write since the last start, so the RAM needs no clearing pass.
`default_nettype none

module windowed_rate_meter import wrm_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  wrm_in_if.sink    in_ch,
  wrm_out_if.source out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_WALK     = 5'b00010,
    ST_DIV_GO   = 5'b00100,
    ST_DIV_WAIT = 5'b01000,
    ST_RESP     = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [PTR_W-1:0]           head_r, head_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [LEVEL_W-1:0]  peak_r, peak_nxt;
  logic signed [LEVEL_W-1:0]  min_r, min_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [RATE_W-1:0]   rate_r, rate_nxt;
  logic signed [RATE_W-1:0]   roll_r, roll_nxt;
  logic [TDT_W-1:0]           tdt_r, tdt_nxt;
  logic signed [TDELTA_W-1:0] tdelta_r, tdelta_nxt;
  logic [PTR_W-1:0]           rptr_r, rptr_nxt;
  logic [CNT_W-1:0]           iss_r, iss_nxt;
  logic                       chk_r, chk_nxt;
  logic [WIN_W-1:0]           win_r, win_nxt;
  logic                       is_q_r, is_q_nxt;

  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [STEP_W-1:0]    ent_dt;
  logic [DELTA_W-1:0]   ent_delta;

  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;
  logic [NUM_W-1:0]     div_num;
  logic [TDELTA_W-1:0]  tdelta_mag;
  logic                 res_neg;
  logic [RATE_W-1:0]    res_rate;

  logic signed [DELTA_W-1:0] delta;
  logic [SUM_W:0]            sum_ext;
  logic [CMP_W-1:0]          walk_sum;
  logic                      stop;
  logic                      issue;
  logic [SAMPLES_W+CNT_W-1:0] held_ext;

  wrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (ram_wdata),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  wrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (tdt_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign ent_dt    = ram_rdata[STEP_W-1:0];
  assign ent_delta = ram_rdata[ENTRY_W-1:STEP_W];

  // magnitude division, sign applied afterward (truncates toward zero)
  always_comb begin
    res_neg    = tdelta_r[TDELTA_W-1];
    tdelta_mag = res_neg ? (~tdelta_r + TDELTA_W'(1)) : tdelta_r;
    div_num    = {tdelta_mag, FRAC_W'(0)};
    if (!res_neg) begin
      res_rate = (|div_quot[NUM_W-1:RATE_W-1]) ? {1'b0, {(RATE_W-1){1'b1}}}
                                               : div_quot[RATE_W-1:0];
    end else if ((|div_quot[NUM_W-1:RATE_W]) ||
                 (div_quot[RATE_W-1] && (|div_quot[RATE_W-2:0]))) begin
      res_rate = {1'b1, {(RATE_W-1){1'b0}}};
    end else begin
      res_rate = ~div_quot[RATE_W-1:0] + RATE_W'(1);
    end
  end

  always_comb begin
    delta     = DELTA_W'(in_ch.payload.level) - DELTA_W'(in_ch.payload.prev_level);
    ram_wdata = {delta, in_ch.payload.step_time};
    sum_ext   = {sum_r[SUM_W-1], sum_r}
              + {{(SUM_W-LEVEL_W+1){in_ch.payload.level[LEVEL_W-1]}}, in_ch.payload.level};
    walk_sum  = CMP_W'(tdt_r) + CMP_W'(ent_dt);
    stop      = chk_r && (walk_sum > CMP_W'(win_r)) && (tdt_r != '0);
    issue     = !stop && (iss_r < cnt_r);
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    peak_nxt   = peak_r;
    min_nxt    = min_r;
    sum_nxt    = sum_r;
    rate_nxt   = rate_r;
    roll_nxt   = roll_r;
    tdt_nxt    = tdt_r;
    tdelta_nxt = tdelta_r;
    rptr_nxt   = rptr_r;
    iss_nxt    = iss_r;
    chk_nxt    = chk_r;
    win_nxt    = win_r;
    is_q_nxt   = is_q_r;
    ram_we     = 1'b0;
    div_start  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          roll_nxt = '0;
          case (in_ch.payload.cmd)
            CMD_START: begin
              head_nxt  = '0;
              cnt_nxt   = '0;
              peak_nxt  = in_ch.payload.level;
              min_nxt   = in_ch.payload.level;
              sum_nxt   = '0;
              rate_nxt  = '0;
              state_nxt = ST_RESP;
            end
            CMD_SAMPLE: begin
              if (in_ch.payload.level > peak_r) begin
                peak_nxt = in_ch.payload.level;
              end
              if (in_ch.payload.level < min_r) begin
                min_nxt = in_ch.payload.level;
              end
              // saturate on signed overflow of the 64-bit sum
              if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
                sum_nxt = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
              end else begin
                sum_nxt = sum_ext[SUM_W-1:0];
              end
              ram_we     = 1'b1;
              head_nxt   = (head_r == PTR_W'(RING_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
              if (cnt_r < CNT_W'(RING_DEPTH)) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
              tdelta_nxt = TDELTA_W'(delta);
              tdt_nxt    = TDT_W'(in_ch.payload.step_time);
              is_q_nxt   = 1'b0;
              state_nxt  = ST_DIV_GO;
            end
            CMD_QUERY: begin
              tdt_nxt    = '0;
              tdelta_nxt = '0;
              rptr_nxt   = (head_r == '0) ? PTR_W'(RING_DEPTH - 1) : head_r - PTR_W'(1);
              iss_nxt    = '0;
              chk_nxt    = 1'b0;
              win_nxt    = in_ch.payload.window_time;
              is_q_nxt   = 1'b1;
              state_nxt  = ST_WALK;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_WALK: begin
        // check the entry read last cycle, issue the next older one
        if (chk_r && !stop) begin
          tdt_nxt    = walk_sum[TDT_W-1:0];
          tdelta_nxt = tdelta_r + TDELTA_W'(signed'(ent_delta));
        end
        chk_nxt = issue;
        if (issue) begin
          rptr_nxt = (rptr_r == '0) ? PTR_W'(RING_DEPTH - 1) : rptr_r - PTR_W'(1);
          iss_nxt  = iss_r + CNT_W'(1);
        end else begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        if (tdt_r > TDT_W'(MIN_DT)) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_WAIT;
        end else begin
          if (is_q_r) begin
            roll_nxt = '0;
          end else begin
            rate_nxt = '0;
          end
          state_nxt = ST_RESP;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (is_q_r) begin
            roll_nxt = res_rate;
          end else begin
            rate_nxt = res_rate;
          end
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      peak_r  <= '0;
      min_r   <= '0;
      sum_r   <= '0;
      rate_r  <= '0;
      roll_r  <= '0;
      iss_r   <= '0;
      chk_r   <= 1'b0;
      is_q_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      peak_r  <= peak_nxt;
      min_r   <= min_nxt;
      sum_r   <= sum_nxt;
      rate_r  <= rate_nxt;
      roll_r  <= roll_nxt;
      iss_r   <= iss_nxt;
      chk_r   <= chk_nxt;
      is_q_r  <= is_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tdt_r    <= tdt_nxt;
    tdelta_r <= tdelta_nxt;
    rptr_r   <= rptr_nxt;
    win_r    <= win_nxt;
  end

  assign held_ext = {SAMPLES_W'(0), cnt_r};

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_RESP);

  always_comb begin
    out_ch.payload.peak_level   = peak_r;
    out_ch.payload.min_level    = min_r;
    out_ch.payload.level_sum    = sum_r;
    out_ch.payload.instant_rate = rate_r;
    out_ch.payload.rolling_rate = roll_r;
    out_ch.payload.samples_held = held_ext[SAMPLES_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/wrm_ram.sv]
`default_nettype none

module wrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/wrm_div.sv]
`default_nettype none

module wrm_div import wrm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]     rem_r;
  logic [NUM_W-1:0]     quo_r;
  logic [DEN_W-1:0]     den_r;

  logic [DEN_W:0] shl;
  logic [DEN_W:0] diff;
  logic           ge;

  // one restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    shl  = {rem_r, quo_r[NUM_W-1]};
    ge   = (shl >= {1'b0, den_r});
    diff = shl - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : shl[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire
